### src/sae_pkg.sv
// Shared widths, constants, register indexes and types of the smoothed acceleration estimator.
package sae_pkg;

    // Field and register widths
    localparam int SPEED_W     = 20;
    localparam int TIME_W      = 48;
    localparam int ACCEL_W     = 32;
    localparam int GAIN_W      = 17;
    localparam int INTERVAL_W  = 20;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 20;

    // Datapath widths
    localparam int DV_W       = SPEED_W + 1;
    localparam int DIVIDEND_W = 41;
    localparam int DIVISOR_W  = TIME_W - 1;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 22;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int SUM_W      = 49;
    localparam int FRAC_W     = 16;
    localparam int QUOT_S_W   = DIVIDEND_W + 1;

    // Constants
    localparam logic [GAIN_W-1:0]     GAIN_ONE       = 17'd65536;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 20'd1000;
    localparam logic [MUL_B_W-1:0]    US_PER_S       = 22'd1000000;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_GAIN = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_INTERVAL   = 4'd1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_DV,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL_NEW,
        ST_MUL_OLD,
        ST_SUM,
        ST_DONE
    } sae_state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### src/sae_div.sv
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
module sae_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [sae_pkg::DIVIDEND_W-1:0]    dividend,
    input  logic [sae_pkg::DIVISOR_W-1:0]     divisor,
    output sae_pkg::div_status_t              status,
    output logic [sae_pkg::DIVIDEND_W-1:0]    quotient
);
    import sae_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W+1:0]  diff;
    logic                  q_bit;
    logic [DIVISOR_W-1:0]  rem_next;

    // Shift in the next dividend bit and try a subtract
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = {1'b0, rem_shift} - {2'b00, dsr_reg};
        q_bit     = ~diff[DIVISOR_W+1];
        rem_next  = q_bit ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], q_bit};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

### src/smoothed_acceleration_estimator_top.sv
// Smoothed acceleration estimator top level: sequencer, shared multiplier and divider.
// Input channel (in_valid/in_ready) takes one velocity sample with its microsecond
// timestamp; output channel (out_valid/out_ready) returns one filtered acceleration
// (Q10 m/s^2) per sample, in order. cfg_valid/cfg_index/cfg_data writes the smoothing
// gain (index 0) and the minimum time step (index 1); cfg_ready is always high.
// Each sample runs through one signed 32x22 multiplier used three times (dv times
// 10^6, new-value weighting, old-value weighting) and a 41-step restoring divider.
// A sample passes MUL_DV, DIV_START, DIV_WAIT (divider steps and done strobe), MUL_NEW,
// MUL_OLD, SUM and DONE before out_valid rises. in_ready returns together with
// out_valid, so a new sample is taken once the last result is loaded. After reset the
// first sample skips the arithmetic, going to DONE with zero. in_ready is high only
// while the sequencer is idle, so one sample is in work at a time; a finished result
// sits in the output register while the next sample is taken. If the receiver stalls,
// the sequencer holds the following result until the output register is free.
// Reset clears the history (no previous sample) and loads gain 65536 and a minimum
// step of 1000 us; the block is ready on the first cycle after reset.
module smoothed_acceleration_estimator_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [sae_pkg::SPEED_W-1:0]     speed,
    input  logic        [sae_pkg::TIME_W-1:0]      sample_time,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [sae_pkg::ACCEL_W-1:0]     acceleration,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [sae_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic        [sae_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sae_pkg::*;

    function automatic logic signed [ACCEL_W-1:0] sat32(input logic signed [QUOT_S_W-1:0] v);
        logic signed [QUOT_S_W-1:0] hi;
        logic signed [QUOT_S_W-1:0] lo;
        hi = QUOT_S_W'({1'b0, {(ACCEL_W-1){1'b1}}});
        lo = -hi - QUOT_S_W'(1);
        if (v > hi)
            return hi[ACCEL_W-1:0];
        else if (v < lo)
            return lo[ACCEL_W-1:0];
        else
            return v[ACCEL_W-1:0];
    endfunction

    sae_state_t state_reg;
    sae_state_t state_next;

    // Configuration
    logic [GAIN_W-1:0]     gain_reg;
    logic [INTERVAL_W-1:0] min_interval_reg;
    logic [GAIN_W-1:0]     gain_eff;
    logic [INTERVAL_W-1:0] min_eff;

    // History
    logic                      have_prev_reg;
    logic signed [SPEED_W-1:0] prev_speed_reg;
    logic [TIME_W-1:0]         prev_time_reg;
    logic signed [ACCEL_W-1:0] prev_accel_reg;

    // Working registers
    logic signed [SPEED_W-1:0] speed_reg;
    logic [TIME_W-1:0]         time_reg;
    logic [DIVISOR_W-1:0]      dt_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      neg_reg;
    logic signed [ACCEL_W-1:0] raw_reg;
    logic signed [SUM_W-1:0]   acc_reg;
    logic signed [ACCEL_W-1:0] result_reg;
    logic                      out_valid_reg;
    logic signed [ACCEL_W-1:0] out_data_reg;

    // Control from the output decode
    logic                      in_take;
    logic                      div_start;
    logic                      out_load;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;

    // Datapath nets
    logic signed [DV_W-1:0]     dv;
    logic [TIME_W-1:0]          d_raw;
    logic                       d_short;
    logic signed [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]          prod_mag;
    div_status_t                div_stat;
    logic [DIVIDEND_W-1:0]      quotient;
    logic signed [QUOT_S_W-1:0] quot_s;
    logic signed [SUM_W-1:0]    sum;

    sae_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_mag[DIVIDEND_W-1:0]),
        .divisor  (dt_reg),
        .status   (div_stat),
        .quotient (quotient)
    );

    // Clamp configuration to its working range
    assign gain_eff = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;
    assign min_eff  = (min_interval_reg == '0) ? INTERVAL_W'(1) : min_interval_reg;

    // Arithmetic around the shared multiplier and divider
    always_comb
    begin
        dv       = DV_W'(speed_reg) - DV_W'(prev_speed_reg);
        d_raw    = time_reg - prev_time_reg;
        d_short  = d_raw[TIME_W-1] || (d_raw < TIME_W'(min_eff));
        prod     = mul_a * mul_b;
        prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        quot_s   = neg_reg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
        sum      = acc_reg + $signed(prod_reg[SUM_W-1:0]);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = have_prev_reg ? ST_MUL_DV : ST_DONE;
            end
            ST_MUL_DV:    state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                    state_next = ST_MUL_NEW;
            end
            ST_MUL_NEW:   state_next = ST_MUL_OLD;
            ST_MUL_OLD:   state_next = ST_SUM;
            ST_SUM:       state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Output decode: handshakes, divider start, multiplier operands
    always_comb
    begin
        in_take   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            ST_IDLE:      in_take = 1'b1;
            ST_MUL_DV:
            begin
                mul_a = MUL_A_W'(dv);
                mul_b = $signed(US_PER_S);
            end
            ST_DIV_START: div_start = 1'b1;
            ST_MUL_NEW:
            begin
                mul_a = raw_reg;
                mul_b = $signed(MUL_B_W'(gain_eff));
            end
            ST_MUL_OLD:
            begin
                mul_a = prev_accel_reg;
                mul_b = $signed(MUL_B_W'(GAIN_ONE - gain_eff));
            end
            ST_DONE:      out_load = !out_valid_reg || out_ready;
            default:      in_take = 1'b0;
        endcase
    end

    assign in_ready     = in_take;
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign acceleration = out_data_reg;

    // Control state, configuration and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            gain_reg         <= GAIN_ONE;
            min_interval_reg <= INTERVAL_RESET;
            have_prev_reg    <= 1'b0;
            prev_speed_reg   <= '0;
            prev_time_reg    <= '0;
            prev_accel_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_SMOOTHING_GAIN: gain_reg         <= cfg_data[GAIN_W-1:0];
                    REG_MIN_INTERVAL:   min_interval_reg <= cfg_data[INTERVAL_W-1:0];
                    default:            gain_reg         <= gain_reg;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                have_prev_reg  <= 1'b1;
                prev_speed_reg <= speed_reg;
                prev_time_reg  <= time_reg;
                prev_accel_reg <= result_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        if (in_take && in_valid)
        begin
            speed_reg <= speed;
            time_reg  <= sample_time;
            if (!have_prev_reg)
                result_reg <= '0;
        end
        if (state_reg == ST_MUL_DV)
        begin
            prod_reg <= prod;
            dt_reg   <= d_short ? DIVISOR_W'(min_eff) : d_raw[DIVISOR_W-1:0];
        end
        if (state_reg == ST_DIV_START)
            neg_reg <= prod_reg[PROD_W-1];
        if (state_reg == ST_DIV_WAIT && div_stat.done)
            raw_reg <= sat32(quot_s);
        if (state_reg == ST_MUL_NEW)
            prod_reg <= prod;
        if (state_reg == ST_MUL_OLD)
        begin
            acc_reg  <= $signed(prod_reg[SUM_W-1:0]);
            prod_reg <= prod;
        end
        if (state_reg == ST_SUM)
            result_reg <= sat32($signed({{(QUOT_S_W-SUM_W+FRAC_W){sum[SUM_W-1]}},
                                         sum[SUM_W-1:FRAC_W]}));
        if (out_load)
            out_data_reg <= result_reg;
    end

`ifndef SYNTHESIS
    // Divider is only started when idle
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // Divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider done outside wait state");

    // First sample after reset goes straight to a zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !have_prev_reg) |=>
            (state_reg == ST_DONE) && (result_reg == '0))
        else $error("first sample did not yield zero");

    // A result is loaded only when the output register is free or draining
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(prev_time_reg))
        else $error("history updated while output stalled");
`endif

endmodule
